@@ sv/srlc_pkg.sv @@
package srlc_pkg;

    // character codes
    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_F    = 8'h46;

    // line checks
    localparam logic [7:0] SUM_GOOD  = 8'hFF;
    localparam logic [8:0] PAIR_SAT  = 9'd256;
    localparam logic [3:0] HEX_A_VAL = 4'd10;

    // position within the line, one-hot
    typedef enum logic [3:0] {
        POS_S     = 4'b0001,
        POS_TYPE  = 4'b0010,
        POS_COUNT = 4'b0100,
        POS_DATA  = 4'b1000
    } pos_t;

    // verdict handed from the parser to the output register
    typedef struct packed {
        logic       ok;
        logic [3:0] rtype;
    } verdict_t;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CHAR_0) && (c <= CHAR_9);
    endfunction

    function automatic logic is_hexup(input logic [7:0] c);
        return (c >= CHAR_A) && (c <= CHAR_F);
    endfunction

    // digit value, 0 for anything that is not a decimal or uppercase hex digit
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (is_dec(c))
        begin
            d = c - CHAR_0;
        end
        else if (is_hexup(c))
        begin
            d = (c - CHAR_A) + {4'd0, HEX_A_VAL};
        end
        return d[3:0];
    endfunction

endpackage

@@ sv/srlc_parse.sv @@
module srlc_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,       // process the held character this cycle
    input  logic [7:0]           char_in,
    input  logic                 line_end,
    output srlc_pkg::verdict_t   verdict     // valid when step and line_end
);
    import srlc_pkg::*;

    pos_t       pos_reg, pos_next;
    logic [3:0] type_digit_reg, type_digit_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic       phase_reg, phase_next;
    logic [7:0] byte_sum_reg, byte_sum_next;
    logic [7:0] declared_reg, declared_next;
    logic [8:0] pair_count_reg, pair_count_next;
    logic       bad_reg, bad_next;

    logic [3:0] nib;
    logic [7:0] byte_val;
    logic [7:0] digit_val;

    assign nib       = nibble_of(char_in);
    assign byte_val  = {high_nibble_reg, nib};
    assign digit_val = char_in - CHAR_0;

    // verdict from the state left by the previous characters
    always_comb
    begin
        verdict.ok    = !bad_reg && (pos_reg == POS_DATA) && !phase_reg &&
                        (pair_count_reg == {1'b0, declared_reg}) &&
                        (byte_sum_reg == SUM_GOOD);
        verdict.rtype = type_digit_reg;
    end

    // per-character state update
    always_comb
    begin
        pos_next         = pos_reg;
        type_digit_next  = type_digit_reg;
        high_nibble_next = high_nibble_reg;
        phase_next       = phase_reg;
        byte_sum_next    = byte_sum_reg;
        declared_next    = declared_reg;
        pair_count_next  = pair_count_reg;
        bad_next         = bad_reg;
        if (step)
        begin
            if (line_end)
            begin
                pos_next         = POS_S;
                type_digit_next  = 4'd0;
                high_nibble_next = 4'd0;
                phase_next       = 1'b0;
                byte_sum_next    = 8'd0;
                declared_next    = 8'd0;
                pair_count_next  = 9'd0;
                bad_next         = 1'b0;
            end
            else
            begin
                case (pos_reg)
                    POS_S:
                    begin
                        if (char_in != CHAR_S)
                        begin
                            bad_next = 1'b1;
                        end
                        pos_next = POS_TYPE;
                    end
                    POS_TYPE:
                    begin
                        if (is_dec(char_in) && !bad_reg)
                        begin
                            type_digit_next = digit_val[3:0];
                        end
                        else
                        begin
                            bad_next = 1'b1;
                        end
                        pos_next = POS_COUNT;
                    end
                    POS_COUNT, POS_DATA:
                    begin
                        if (!is_dec(char_in) && !is_hexup(char_in))
                        begin
                            bad_next = 1'b1;
                        end
                        if (!phase_reg)
                        begin
                            high_nibble_next = nib;
                            phase_next       = 1'b1;
                        end
                        else
                        begin
                            phase_next    = 1'b0;
                            byte_sum_next = byte_sum_reg + byte_val;
                            if (pos_reg == POS_COUNT)
                            begin
                                declared_next = byte_val;
                                pos_next      = POS_DATA;
                            end
                            else if (pair_count_reg != PAIR_SAT)
                            begin
                                pair_count_next = pair_count_reg + 9'd1;
                            end
                        end
                    end
                    default:
                    begin
                        pos_next = POS_S;
                    end
                endcase
            end
        end
    end

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= POS_S;
            type_digit_reg  <= 4'd0;
            high_nibble_reg <= 4'd0;
            phase_reg       <= 1'b0;
            byte_sum_reg    <= 8'd0;
            declared_reg    <= 8'd0;
            pair_count_reg  <= 9'd0;
            bad_reg         <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            type_digit_reg  <= type_digit_next;
            high_nibble_reg <= high_nibble_next;
            phase_reg       <= phase_next;
            byte_sum_reg    <= byte_sum_next;
            declared_reg    <= declared_next;
            pair_count_reg  <= pair_count_next;
            bad_reg         <= bad_next;
        end
    end

endmodule

@@ sv/srecord_line_checker_core.sv @@
// channel  | direction | tdata (low bit up)                 | tlast
// s_axis   | in        | char_in[7:0]                       | line_end
// m_axis   | out       | record_ok, record_type[3:0], 3'b0  | -
//
// One character per cycle sustained. A character is held in the input register,
// then the parser updates the line state from it. A terminator writes its
// verdict into the output register. Characters keep flowing while a verdict
// waits; only a second terminator stalls on a full output register. Reset
// clears the line state and both valid flags.
module srecord_line_checker_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // char_in[7:0]
    input  logic       s_axis_tlast,   // line_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // record_ok, record_type[3:0], zero pad
);
    import srlc_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_end_reg;
    logic       out_valid_reg;
    verdict_t   out_reg;
    verdict_t   verdict;
    logic       out_free;
    logic       step;

    // a character always advances; a terminator needs room for its verdict
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && (!in_end_reg || out_free);
    assign s_axis_tready = !in_valid_reg || step;

    srlc_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .char_in  (in_char_reg),
        .line_end (in_end_reg),
        .verdict  (verdict)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tlast;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && in_end_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_end_reg)
        begin
            out_reg <= verdict;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.rtype, out_reg.ok};

endmodule

@@ tb/srlc_verdict_monitor.sv @@
`timescale 1ns / 1ps

module srlc_verdict_monitor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    input  logic       char_ready,
    input  logic [7:0] char_data,      // char_in[7:0]
    input  logic       char_last,      // line_end
    input  logic       verdict_valid,
    input  logic       verdict_ready,
    input  logic [7:0] verdict_data,   // record_ok, record_type[3:0], zero pad
    output int         fail_count,
    output int         pending_verdicts
);
    import srlc_pkg::*;

    // line state as the predictor sees it
    pos_t       line_pos;
    logic [3:0] type_val;
    logic [3:0] upper_nib;
    logic       half_pair;
    logic [7:0] sum_acc;
    logic [7:0] count_byte;
    logic [8:0] pairs_seen;
    logic       format_err;

    verdict_t   expected_verdicts[$];

    task automatic clear_line();
        begin
            line_pos   = POS_S;
            type_val   = 4'd0;
            upper_nib  = 4'd0;
            half_pair  = 1'b0;
            sum_acc    = 8'd0;
            count_byte = 8'd0;
            pairs_seen = 9'd0;
            format_err = 1'b0;
        end
    endtask

    task automatic flag_error(input string what, input int want_val, input int got_val);
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, what, want_val, got_val);
        end
    endtask

    // advance the line state by one character, queue a verdict on a terminator
    task automatic take_char(input logic [7:0] c, input logic term);
        logic       is_digit;
        logic       is_upper;
        logic [3:0] nib;
        logic [7:0] full_byte;
        verdict_t   v;
        begin
            is_digit = (c >= CHAR_0) && (c <= CHAR_9);
            is_upper = (c >= CHAR_A) && (c <= CHAR_F);
            if (term)
            begin
                v.ok    = !format_err && (line_pos == POS_DATA) && !half_pair &&
                          (pairs_seen == {1'b0, count_byte}) && (sum_acc == SUM_GOOD);
                v.rtype = type_val;
                expected_verdicts.push_back(v);
                clear_line();
            end
            else
            begin
                case (line_pos)
                    POS_S:
                    begin
                        if (c != CHAR_S)
                            format_err = 1'b1;
                        line_pos = POS_TYPE;
                    end
                    POS_TYPE:
                    begin
                        if (is_digit && !format_err)
                            type_val = 4'(c - CHAR_0);
                        else
                            format_err = 1'b1;
                        line_pos = POS_COUNT;
                    end
                    default:
                    begin
                        // bad characters still pair up, as digit zero
                        nib = 4'd0;
                        if (is_digit)
                            nib = 4'(c - CHAR_0);
                        else if (is_upper)
                            nib = 4'(c - CHAR_A) + HEX_A_VAL;
                        else
                            format_err = 1'b1;
                        if (!half_pair)
                        begin
                            upper_nib = nib;
                            half_pair = 1'b1;
                        end
                        else
                        begin
                            full_byte = {upper_nib, nib};
                            half_pair = 1'b0;
                            sum_acc   = sum_acc + full_byte;
                            if (line_pos == POS_COUNT)
                            begin
                                count_byte = full_byte;
                                line_pos   = POS_DATA;
                            end
                            else if (pairs_seen < PAIR_SAT)
                                pairs_seen = pairs_seen + 9'd1;
                        end
                    end
                endcase
            end
        end
    endtask

    // verdicts are compared before the same edge's character is taken
    always @(posedge clk)
    begin : watch_channels
        verdict_t got;
        verdict_t want;
        if (!rst_n)
        begin
            clear_line();
            expected_verdicts.delete();
            fail_count = 0;
        end
        else
        begin
            if (verdict_valid && verdict_ready)
            begin
                got.ok    = verdict_data[0];
                got.rtype = verdict_data[4:1];
                if (expected_verdicts.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected verdict, record_ok %0d, record_type %0d",
                                 $time, got.ok, got.rtype);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got.ok !== want.ok)
                        flag_error("record_ok", int'(want.ok), int'(got.ok));
                    if (got.rtype !== want.rtype)
                        flag_error("record_type", int'(want.rtype), int'(got.rtype));
                end
            end
            if (char_valid && char_ready)
                take_char(char_data, char_last);
        end
        pending_verdicts = expected_verdicts.size();
    end

endmodule

@@ tb/tb_srecord_line_checker_core.sv @@
`timescale 1ns / 1ps

module tb_srecord_line_checker_core;
    import srlc_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int CHAR_BUDGET = 1450;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;

    int         fail_count;
    int         pending_verdicts;
    logic       char_taken;
    int         idle_cycles;
    logic       src_gaps_on;
    logic       sink_stalls_on;
    int         chars_sent;
    logic [7:0] line_buf[$];

    srecord_line_checker_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    srlc_verdict_monitor u_verdict_mon (
        .clk              (clk),
        .rst_n            (rst_n),
        .char_valid       (s_axis_tvalid),
        .char_ready       (s_axis_tready),
        .char_data        (s_axis_tdata),
        .char_last        (s_axis_tlast),
        .verdict_valid    (m_axis_tvalid),
        .verdict_ready    (m_axis_tready),
        .verdict_data     (m_axis_tdata),
        .fail_count       (fail_count),
        .pending_verdicts (pending_verdicts)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // input transaction flag, read back at the falling edge
    always @(posedge clk)
        char_taken <= s_axis_tvalid && s_axis_tready;

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_srecord_line_checker_core: FAIL");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < HEX_A_VAL)
            return CHAR_0 + n;
        return CHAR_A + (n - HEX_A_VAL);
    endfunction

    task automatic push_hex(input logic [7:0] b);
        begin
            line_buf.push_back(hex_char(b[7:4]));
            line_buf.push_back(hex_char(b[3:0]));
        end
    endtask

    task automatic load_text(input string s);
        begin
            line_buf.delete();
            for (int i = 0; i < s.len(); i++)
                line_buf.push_back(s[i]);
        end
    endtask

    // record with count byte, data bytes and checksum; well-formed for up to 254 data bytes
    task automatic build_record(input int n_data, input logic [3:0] rtype);
        logic [7:0] cnt;
        logic [7:0] sum;
        logic [7:0] b;
        begin
            line_buf.delete();
            line_buf.push_back(CHAR_S);
            line_buf.push_back(CHAR_0 + rtype);
            cnt = 8'(n_data + 1);
            sum = cnt;
            push_hex(cnt);
            repeat (n_data)
            begin
                b   = 8'($urandom_range(0, 255));
                sum = sum + b;
                push_hex(b);
            end
            push_hex(SUM_GOOD - sum);
        end
    endtask

    // break a well-formed record in one of several ways
    task automatic corrupt_record();
        int idx;
        int k;
        begin
            idx = $urandom_range(2, line_buf.size() - 1);
            case ($urandom_range(0, 8))
                0: line_buf[0] = 8'($urandom_range(0, 255));
                1: line_buf[1] = 8'($urandom_range(0, 255));
                2: line_buf[idx] = 8'($urandom_range(0, 255));
                3: line_buf[idx] = 8'h61 + 8'($urandom_range(0, 5));   // lowercase hex
                4: line_buf.delete(idx);                               // odd digit count
                5: line_buf[line_buf.size() - 1] = hex_char(4'($urandom_range(0, 15)));
                6: begin
                    line_buf[2] = hex_char(4'($urandom_range(0, 15)));
                    line_buf[3] = hex_char(4'($urandom_range(0, 15)));
                end
                7: begin
                    k = $urandom_range(0, line_buf.size() - 1);
                    while (line_buf.size() > k)
                        void'(line_buf.pop_back());
                end
                default: push_hex(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // one character transaction, called at a falling edge
    task automatic send_char(input logic [7:0] c, input logic term);
        int gap;
        begin
            gap = src_gaps_on ? pick_gap() : 0;
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_axis_tvalid = 1'b1;
            s_axis_tdata  = c;
            s_axis_tlast  = term;
            @(negedge clk);
            while (!char_taken)
                @(negedge clk);
            chars_sent++;
        end
    endtask

    task automatic send_line(input logic [7:0] term_char);
        begin
            src_gaps_on = ($urandom_range(0, 3) != 0);
            foreach (line_buf[i])
                send_char(line_buf[i], 1'b0);
            send_char(term_char, 1'b1);
        end
    endtask

    // result side ready, with random stalls and stall-free stretches
    initial
    begin : sink_driver
        int stall_left;
        m_axis_tready  = 1'b0;
        sink_stalls_on = 1'b1;
        stall_left     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0)
                sink_stalls_on = !sink_stalls_on;
            if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready = 1'b1;
                if (sink_stalls_on && ($urandom_range(0, 3) == 0))
                    stall_left = pick_gap();
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int line_idx;
        int long_idx;
        int r;
        int n;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        chars_sent    = 0;
        src_gaps_on   = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // good record with the highest type digit
        load_text("S901FE");
        send_line(8'h0A);
        // line ends right after the 'S'
        load_text("S");
        send_line(8'h0D);
        // missing 'S'
        load_text("T5");
        send_line(8'hFF);
        // type is not a digit
        load_text("S:");
        send_line(8'h00);
        // odd number of hex digits
        load_text("S10");
        send_line(8'h0A);
        // terminator only
        load_text("");
        send_line(8'h0A);
        // invalid hex character in the checksum
        load_text("S001FG");
        send_line(8'h0A);

        // random lines, one of them long enough to saturate the pair count
        line_idx = 0;
        long_idx = $urandom_range(2, 15);
        while (chars_sent < CHAR_BUDGET)
        begin
            r = $urandom_range(0, 99);
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(9, 30);
            if (line_idx == long_idx)
                build_record($urandom_range(257, 260), 4'($urandom_range(0, 9)));
            else if (r < 60)
                build_record(n, 4'($urandom_range(0, 9)));
            else if (r < 90)
            begin
                build_record(n, 4'($urandom_range(0, 9)));
                corrupt_record();
            end
            else
            begin
                line_buf.delete();
                repeat ($urandom_range(0, 6))
                    line_buf.push_back(8'($urandom_range(0, 255)));
            end
            send_line(8'($urandom_range(0, 255)));
            line_idx++;
        end
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;

        // drain
        while (pending_verdicts != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if ((fail_count == 0) && (pending_verdicts == 0))
            $display("tb_srecord_line_checker_core: PASS");
        else
            $display("tb_srecord_line_checker_core: FAIL");
        $finish;
    end

endmodule
